// ===== src/strs_pkg.sv =====
// Shared constants for the segment tree range sum block.
// Holds default sizes, the result width and the action codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package strs_pkg;

	// default tree size and leaf value width
	localparam int unsigned LEAVES_DEF  = 1024;
	localparam int unsigned VALUE_W_DEF = 16;

	// width of the delivered range sum
	localparam int unsigned SUM_W = 26;

	// action codes of an input word
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

endpackage

`default_nettype wire

// ===== src/segment_tree_range_sum_core.sv =====
// Segment tree range sum core: point write, inclusive range sum query.
// Depends on strs_pkg and strs_ram.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word: action, leaf_index,
//   leaf_value, range_low, range_high. A write word (action 0) sets one leaf
//   and rebuilds its ancestors; it gives no result. A query word (action 1)
//   gives one output word, range_sum, on out_valid/out_ready. An inverted
//   range gives 0.
//   The node sums live in one RAM of 2*LEAVES entries with a registered read.
//   Words are handled one at a time; in_ready is high only while idle.
//   A write does one RAM read and one write per tree level. A query walks the
//   tree with one RAM read per visited node. After reset the core clears all
//   2*LEAVES RAM entries, one entry per cycle, with in_ready low.
//   The result sits in an output register; a new word can be taken while it
//   waits. If a second query finishes while the receiver still stalls, the
//   core holds that query until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module segment_tree_range_sum_core #(
	parameter int unsigned LEAVES      = strs_pkg::LEAVES_DEF,
	parameter int unsigned VALUE_WIDTH = strs_pkg::VALUE_W_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        action,
	input  wire logic [$clog2(LEAVES)-1:0]   leaf_index,
	input  wire logic [VALUE_WIDTH-1:0]      leaf_value,
	input  wire logic [$clog2(LEAVES)-1:0]   range_low,
	input  wire logic [$clog2(LEAVES)-1:0]   range_high,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [strs_pkg::SUM_W-1:0]  range_sum
);

	import strs_pkg::*;

	localparam int unsigned IDX_W  = $clog2(LEAVES);
	localparam int unsigned ADDR_W = IDX_W + 1;
	localparam int unsigned PTR_W  = IDX_W + 2;
	localparam int unsigned DEPTH  = 2 * LEAVES;
	localparam int unsigned NODE_W = VALUE_WIDTH + IDX_W;

	typedef enum logic [3:0] {
		ST_CLR  = 4'b0001,
		ST_IDLE = 4'b0010,
		ST_UPD  = 4'b0100,
		ST_QRY  = 4'b1000
	} state_t;

	typedef enum logic {
		SIDE_L = 1'b0,
		SIDE_R = 1'b1
	} side_t;

	state_t              state_q;
	side_t               side_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [ADDR_W-1:0]   k_q;
	logic [NODE_W-1:0]   cur_q;
	logic                pend_q;
	logic [PTR_W-1:0]    l_q;
	logic [PTR_W-1:0]    r_q;
	logic [SUM_W-1:0]    acc_q;
	logic [SUM_W-1:0]    out_q;
	logic                out_valid_q;

	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [NODE_W-1:0]   mem_wdata;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_raddr;
	logic [NODE_W-1:0]   mem_rdata;

	logic [ADDR_W-1:0]   par;
	logic [NODE_W-1:0]   sum_up;
	logic [SUM_W-1:0]    acc_nx;
	logic                q_done;
	logic                q_fire;
	logic                out_free;
	logic [PTR_W-1:0]    r_dec;

	strs_ram #(
		.WIDTH (NODE_W),
		.DEPTH (DEPTH)
	) u_node_ram (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	// datapath helpers
	assign par      = k_q >> 1;
	assign sum_up   = cur_q + mem_rdata;
	assign acc_nx   = pend_q ? (acc_q + SUM_W'(mem_rdata)) : acc_q;
	assign q_done   = (l_q >= r_q);
	assign out_free = !out_valid_q || out_ready;
	assign r_dec    = r_q - PTR_W'(1);
	assign q_fire   = (state_q == ST_QRY) && (side_q == SIDE_L) && q_done
		&& !pend_q && out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign range_sum = out_q;

	// RAM port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_UPD: begin
				mem_we = 1'b1;
				mem_re = 1'b1;
				if (!pend_q) begin
					// leaf write, fetch its sibling
					mem_waddr = k_q;
					mem_wdata = cur_q;
					mem_raddr = k_q ^ ADDR_W'(1);
				end else begin
					// parent write, fetch the parent's sibling
					mem_waddr = par;
					mem_wdata = sum_up;
					mem_raddr = par ^ ADDR_W'(1);
				end
			end
			ST_QRY: begin
				if (side_q == SIDE_L) begin
					if (!q_done && l_q[0]) begin
						mem_re    = 1'b1;
						mem_raddr = l_q[ADDR_W-1:0];
					end
				end else begin
					if (r_q[0]) begin
						mem_re    = 1'b1;
						mem_raddr = r_dec[ADDR_W-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			side_q      <= SIDE_L;
			clr_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: a finished query loads it, the receiver drains it
			if (q_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						pend_q <= 1'b0;
						side_q <= SIDE_L;
						if (action == ACT_WRITE) begin
							state_q <= ST_UPD;
						end else begin
							state_q <= ST_QRY;
						end
					end
				end
				ST_UPD: begin
					if (pend_q && par == ADDR_W'(1)) begin
						state_q <= ST_IDLE;
						pend_q  <= 1'b0;
					end else begin
						pend_q <= 1'b1;
					end
				end
				ST_QRY: begin
					pend_q <= mem_re;
					if (side_q == SIDE_L) begin
						if (!q_done) begin
							side_q <= SIDE_R;
						end else if (q_fire) begin
							state_q <= ST_IDLE;
						end
					end else begin
						side_q <= SIDE_L;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					k_q   <= {1'b1, leaf_index};
					cur_q <= NODE_W'(leaf_value);
					acc_q <= '0;
					if (range_low > range_high) begin
						l_q <= '0;
						r_q <= '0;
					end else begin
						l_q <= {2'b01, range_low};
						r_q <= {2'b01, range_high} + PTR_W'(1);
					end
				end
			end
			ST_UPD: begin
				if (pend_q) begin
					k_q   <= par;
					cur_q <= sum_up;
				end
			end
			ST_QRY: begin
				acc_q <= acc_nx;
				if (side_q == SIDE_L) begin
					if (!q_done && l_q[0]) begin
						l_q <= l_q + PTR_W'(1);
					end else if (q_done && !pend_q && out_free) begin
						out_q <= acc_q;
					end
				end else begin
					l_q <= l_q >> 1;
					r_q <= r_q >> 1;
				end
			end
			default: begin
			end
		endcase
	end

	// write and read never hit the same entry in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("RAM read and write to the same entry");

	// no read left unconsumed when a new word is taken
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_q)
		else $error("pending RAM read while idle");

	// query window never inverts
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QRY) |-> (l_q <= r_q))
		else $error("query window inverted");

	// update walk never reaches the unused slot
	a_upd_node: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> (k_q != '0))
		else $error("update walked past the root");

	// a result is only raised by a finished query
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_QRY))
		else $error("result raised outside a query");

endmodule

`default_nettype wire

// ===== src/strs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the node sum store. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module strs_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for segment_tree_range_sum_core: leaf writes and range sum queries.
// Depends on strs_pkg and the core RTL. A shadow copy of the leaves predicts
// each sum, and a scoreboard checks the results in order.
`timescale 1ns / 1ps

// Tracks leaf contents and the sums still owed by the core
class leaf_sum_tracker;
	localparam int unsigned LEAF_CNT = strs_pkg::LEAVES_DEF;
	localparam int unsigned VAL_W    = strs_pkg::VALUE_W_DEF;
	localparam int unsigned SUM_W    = strs_pkg::SUM_W;

	bit [VAL_W-1:0] leaf_vals [LEAF_CNT];
	bit [SUM_W-1:0] pending_sums [$];
	int unsigned    bad_cnt;
	int unsigned    checked_cnt;
	int unsigned    write_cnt;
	int unsigned    query_cnt;
	int unsigned    empty_cnt;

	function new();
		foreach (leaf_vals[i]) leaf_vals[i] = '0;
		bad_cnt     = 0;
		checked_cnt = 0;
		write_cnt   = 0;
		query_cnt   = 0;
		empty_cnt   = 0;
	endfunction

	// inclusive sum over [lo, hi]; inverted span is empty
	function bit [SUM_W-1:0] sum_span(int unsigned lo, int unsigned hi);
		longint unsigned acc;
		acc = 0;
		if (lo > hi || lo >= LEAF_CNT)
			return '0;
		if (hi >= LEAF_CNT)
			hi = LEAF_CNT - 1;
		for (int unsigned i = lo; i <= hi; i++)
			acc += leaf_vals[i];
		return acc[SUM_W-1:0];
	endfunction

	// called for every word the core takes
	function void note_word(logic act, int unsigned idx, bit [VAL_W-1:0] val,
			int unsigned lo, int unsigned hi);
		if (act == strs_pkg::ACT_WRITE) begin
			leaf_vals[idx % LEAF_CNT] = val;
			write_cnt++;
		end else begin
			pending_sums.push_back(sum_span(lo, hi));
			query_cnt++;
			if (lo > hi)
				empty_cnt++;
		end
	endfunction

	// called for every sum the core hands out
	function void check_sum(logic [SUM_W-1:0] got);
		bit [SUM_W-1:0] want;
		if (pending_sums.size() == 0) begin
			bad_cnt++;
			if (bad_cnt <= 10)
				$display("tb: range sum %0d arrived with none outstanding", got);
			return;
		end
		want = pending_sums.pop_front();
		checked_cnt++;
		if (got !== want) begin
			bad_cnt++;
			if (bad_cnt <= 10)
				$display("tb: range sum mismatch: expected %0d, got %0d", want, got);
		end
	endfunction
endclass

module tb;
	import strs_pkg::*;

	localparam int unsigned IDX_W    = $clog2(LEAVES_DEF);
	localparam int unsigned VAL_W    = VALUE_W_DEF;
	localparam int unsigned LAST_IDX = LEAVES_DEF - 1;
	localparam int unsigned VAL_MAX  = (1 << VAL_W) - 1;
	localparam int unsigned PHASE_WORDS = 276;

	logic             clk;
	logic             arst_n     = 1'b0;
	logic             in_valid   = 1'b0;
	logic             in_ready;
	logic             action     = ACT_WRITE;
	logic [IDX_W-1:0] leaf_index = '0;
	logic [VAL_W-1:0] leaf_value = '0;
	logic [IDX_W-1:0] range_low  = '0;
	logic [IDX_W-1:0] range_high = '0;
	logic             out_valid;
	logic             out_ready  = 1'b0;
	logic [SUM_W-1:0] range_sum;

	leaf_sum_tracker tracker;
	int unsigned     tx_idle_pct = 0;
	int unsigned     rx_idle_pct = 0;

	segment_tree_range_sum_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.leaf_index (leaf_index),
		.leaf_value (leaf_value),
		.range_low  (range_low),
		.range_high (range_high),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.range_sum  (range_sum)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: stalls on a random share of cycles
	initial begin
		forever begin
			@(posedge clk);
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// sums leaving the core
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_sum(range_sum);
	end

	// present one word, hold it until taken; called at a rising edge
	task automatic send_word(input logic act, input int unsigned idx,
			input int unsigned val, input int unsigned lo, input int unsigned hi);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		leaf_index <= idx[IDX_W-1:0];
		leaf_value <= val[VAL_W-1:0];
		range_low  <= lo[IDX_W-1:0];
		range_high <= hi[IDX_W-1:0];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.note_word(act, idx[IDX_W-1:0], val[VAL_W-1:0], lo[IDX_W-1:0],
			hi[IDX_W-1:0]);
	endtask

	// unused fields carry random junk that the core must ignore
	task automatic send_write(input int unsigned idx, input int unsigned val);
		send_word(ACT_WRITE, idx, val, $urandom_range(LAST_IDX), $urandom_range(LAST_IDX));
	endtask

	task automatic send_query(input int unsigned lo, input int unsigned hi);
		send_word(ACT_QUERY, $urandom_range(LAST_IDX), $urandom_range(VAL_MAX), lo, hi);
	endtask

	// mostly writes with heavy values, queries over varied span shapes
	task automatic send_random_words(input int unsigned count);
		int unsigned idx;
		int unsigned val;
		int unsigned lo;
		int unsigned hi;
		for (int unsigned n = 0; n < count; n++) begin
			if ($urandom_range(99) < 55) begin
				case ($urandom_range(3))
					0: idx = $urandom_range(31);
					1: idx = ($urandom_range(1)) ? LAST_IDX : 0;
					default: idx = $urandom_range(LAST_IDX);
				endcase
				case ($urandom_range(4))
					0: val = VAL_MAX;
					1: val = 0;
					2: val = $urandom_range(VAL_MAX);
					default: val = $urandom_range(VAL_MAX, VAL_MAX - 4095);
				endcase
				send_write(idx, val);
			end else begin
				lo = $urandom_range(LAST_IDX);
				case ($urandom_range(7))
					0: hi = $urandom_range(LAST_IDX);
					1: hi = lo;
					2: begin
						lo = 0;
						hi = $urandom_range(LAST_IDX);
					end
					3: hi = LAST_IDX;
					4: begin
						lo = 0;
						hi = LAST_IDX;
					end
					5: hi = (lo + $urandom_range(15) > LAST_IDX) ?
						LAST_IDX : lo + $urandom_range(15);
					6: begin
						lo = $urandom_range(LAST_IDX, 1);
						hi = $urandom_range(lo - 1);
					end
					default: hi = (lo + $urandom_range(200) > LAST_IDX) ?
						LAST_IDX : lo + $urandom_range(200);
				endcase
				send_query(lo, hi);
			end
		end
	endtask

	initial begin
		tracker = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: cleared store, extreme leaves and values, empty spans
		send_query(0, LAST_IDX);
		send_write(0, VAL_MAX);
		send_write(LAST_IDX, VAL_MAX);
		send_write(512, 16'h8000);
		send_write(1, 1);
		send_write(511, 16'hAAAA);
		send_write(513, 16'h5555);
		send_query(0, 0);
		send_query(LAST_IDX, LAST_IDX);
		send_query(0, LAST_IDX);
		send_query(5, 3);
		send_query(LAST_IDX, 0);
		send_query(512, 512);
		send_query(1, LAST_IDX - 1);
		send_query(511, 513);
		send_query(0, 1);
		send_write(0, 0);
		send_write(LAST_IDX, 16'h1234);
		send_query(0, LAST_IDX);
		send_query(LAST_IDX - 1, LAST_IDX);
		send_query(0, 511);

		// random: receiver-heavy idling, sender-heavy idling, then none
		tx_idle_pct = 28;
		rx_idle_pct = 55;
		send_random_words(PHASE_WORDS);
		tx_idle_pct = 55;
		rx_idle_pct = 28;
		send_random_words(PHASE_WORDS);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_random_words(PHASE_WORDS);
		in_valid <= 1'b0;

		// drain, then allow for a trailing write walk
		while (tracker.pending_sums.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);

		$display("tb: %0d words taken: %0d leaf writes, %0d range queries (%0d empty)",
			tracker.write_cnt + tracker.query_cnt, tracker.write_cnt,
			tracker.query_cnt, tracker.empty_cnt);
		$display("tb: %0d sums checked across three idling mixes, %0d mismatches",
			tracker.checked_cnt, tracker.bad_cnt);
		if (tracker.bad_cnt == 0 && tracker.pending_sums.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("tb: timeout with %0d sums outstanding", tracker.pending_sums.size());
		$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== segment_tree_range_sum_core.f =====
src/strs_pkg.sv
src/strs_ram.sv
src/segment_tree_range_sum_core.sv
verif/tb.sv
